@@ rtl/tgard_pkg.sv @@
package tgard_pkg;

  localparam logic [1:0] FMT_8  = 2'd0;
  localparam logic [1:0] FMT_16 = 2'd1;
  localparam logic [1:0] FMT_24 = 2'd2;
  localparam logic [1:0] FMT_32 = 2'd3;

  localparam logic [2:0] CFG_PIXEL_FORMAT = 3'd0;
  localparam logic [2:0] CFG_RLE_ON       = 3'd1;
  localparam logic [2:0] CFG_ALPHA_ON     = 3'd2;
  localparam logic [2:0] CFG_MAPPED       = 3'd3;
  localparam logic [2:0] CFG_PIXEL_TOTAL  = 3'd4;

  localparam logic [7:0] RUN_FLAG = 8'h80;

  // Completed pixel on its way to conversion
  typedef struct packed {
    logic [31:0] pix_bytes;
    logic [1:0]  fmt;
    logic        mapped;
    logic        alpha_on;
    logic [7:0]  run;
    logic        last;
  } pix_t;

  typedef struct packed {
    logic [15:0] index_value;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  run_length;
    logic        last_pixel;
  } res_t;

endpackage

@@ rtl/tgard_ifs.sv @@
interface tgard_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface tgard_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] index_value;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  run_length;
  logic        last_pixel;

  modport source (output valid, output index_value, output red, output green,
                  output blue, output run_length, output last_pixel, input ready);
  modport sink   (input valid, input index_value, input red, input green,
                  input blue, input run_length, input last_pixel, output ready);
endinterface

interface tgard_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/tgard_convert.sv @@
module tgard_convert (
  input  tgard_pkg::pix_t pix,
  output tgard_pkg::res_t res
);
  import tgard_pkg::*;

  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [15:0] s;
    begin
      // exact floor(p/255) for p up to 255*255
      s = p + {8'd0, p[15:8]} + 16'd1;
      return s[15:8];
    end
  endfunction

  logic [7:0]  b0, b1, b2, b3;
  logic [15:0] prod_r, prod_g, prod_b;

  assign b0 = pix.pix_bytes[7:0];
  assign b1 = pix.pix_bytes[15:8];
  assign b2 = pix.pix_bytes[23:16];
  assign b3 = pix.pix_bytes[31:24];

  assign prod_r = b2 * b3;
  assign prod_g = b1 * b3;
  assign prod_b = b0 * b3;

  always_comb begin
    res.index_value = 16'd0;
    res.red         = 8'd0;
    res.green       = 8'd0;
    res.blue        = 8'd0;
    res.run_length  = pix.run;
    res.last_pixel  = pix.last;
    unique case (pix.fmt)
      FMT_8: begin
        res.index_value = {8'd0, b0};
      end
      FMT_16: begin
        if (pix.mapped) begin
          res.index_value = {b1, b0};
        end else begin
          res.blue  = {b0[4:0], 3'd0};
          res.green = {b1[1:0], b0[7:5], 3'd0};
          res.red   = {b1[6:2], 3'd0};
        end
      end
      FMT_24: begin
        res.blue  = b0;
        res.green = b1;
        res.red   = b2;
      end
      FMT_32: begin
        if (pix.alpha_on) begin
          res.blue  = div255(prod_b);
          res.green = div255(prod_g);
          res.red   = div255(prod_r);
        end else begin
          res.blue  = b0;
          res.green = b1;
          res.red   = b2;
        end
      end
      default: begin
        res.index_value = 16'd0;
      end
    endcase
  end

endmodule

@@ rtl/tga_rle_pixel_decoder_top.sv @@
// Image-data pixel decoder for run-length or raw encoded picture streams.
// in_ch  : one image-data byte per item (data_byte), valid/ready.
// out_ch : one decoded pixel per item: index_value or red/green/blue,
//          run_length (already clipped to the pixels left) and last_pixel
//          on the run that finishes the image.
// cfg_ch : register writes (index, data), always ready. Write only while
//          idle. Writing pixel_total starts a new image.
// Packet headers and non-final pixel bytes give no output item; bytes
// arriving after the image is finished are taken and dropped.
// Pipeline: the byte completing a pixel is taken into the stage register
// with the packet state update, then converted (with the alpha multiply)
// into the output register, where out_ch.valid rises.
// Throughput: one byte per cycle while out_ch is not stalled; the packet
// and pixel counters update in the cycle a byte is taken.
// Reset: registers return to their defaults (24-bit BGR, raw, no alpha,
// unmapped, pixel_total 1), no item in flight.
// Stall: when out_ch.ready is low with a result pending the whole pipe
// holds and in_ch.ready drops; the output register keeps its item.
module tga_rle_pixel_decoder_top (
  input  logic          clk,
  input  logic          rst_n,
  tgard_byte_if.sink    in_ch,
  tgard_pix_if.source   out_ch,
  tgard_cfg_if.sink     cfg_ch
);
  import tgard_pkg::*;

  logic [1:0]  fmt_r;
  logic        rle_on_r;
  logic        alpha_on_r;
  logic        mapped_r;

  logic [7:0]  packet_left_r, packet_left_nxt;
  logic        packet_repeat_r, packet_repeat_nxt;
  logic [1:0]  byte_slot_r, byte_slot_nxt;
  logic [31:0] pixel_bytes_r, pixel_bytes_nxt;
  logic [31:0] pixels_left_r, pixels_left_nxt;

  logic        s1_valid_r, s1_valid_nxt;
  pix_t        s1_r, s1_nxt;
  logic        out_valid_r;
  res_t        out_r;
  res_t        conv;

  logic        advance;
  logic        in_acc;
  logic        cfg_acc;
  logic [31:0] bytes_cur;
  logic [7:0]  run_raw;
  logic [7:0]  run_clip;

  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = advance;
  assign in_acc       = in_ch.valid && advance;
  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid;

  assign bytes_cur = pixel_bytes_r | ({24'd0, in_ch.data_byte} << {byte_slot_r, 3'd0});

  always_comb begin
    packet_left_nxt   = packet_left_r;
    packet_repeat_nxt = packet_repeat_r;
    byte_slot_nxt     = byte_slot_r;
    pixel_bytes_nxt   = pixel_bytes_r;
    pixels_left_nxt   = pixels_left_r;
    s1_valid_nxt      = 1'b0;
    run_raw           = 8'd1;
    run_clip          = 8'd1;
    s1_nxt.pix_bytes  = bytes_cur;
    s1_nxt.fmt        = fmt_r;
    s1_nxt.mapped     = mapped_r;
    s1_nxt.alpha_on   = alpha_on_r;
    s1_nxt.run        = 8'd1;
    s1_nxt.last       = 1'b0;
    if (in_acc && pixels_left_r != 32'd0) begin
      if (rle_on_r && packet_left_r == 8'd0) begin
        packet_repeat_nxt = |(in_ch.data_byte & RUN_FLAG);
        packet_left_nxt   = {1'b0, in_ch.data_byte[6:0]} + 8'd1;
      end else if (byte_slot_r < fmt_r) begin
        byte_slot_nxt   = byte_slot_r + 2'd1;
        pixel_bytes_nxt = bytes_cur;
      end else begin
        byte_slot_nxt   = 2'd0;
        pixel_bytes_nxt = 32'd0;
        if (rle_on_r && packet_repeat_r) begin
          run_raw         = packet_left_r;
          packet_left_nxt = 8'd0;
        end else if (rle_on_r) begin
          packet_left_nxt = packet_left_r - 8'd1;
        end
        if ({24'd0, run_raw} > pixels_left_r) begin
          run_clip = pixels_left_r[7:0];
        end else begin
          run_clip = run_raw;
        end
        pixels_left_nxt = pixels_left_r - {24'd0, run_clip};
        s1_valid_nxt    = 1'b1;
        s1_nxt.run      = run_clip;
        s1_nxt.last     = (pixels_left_nxt == 32'd0);
      end
    end
  end

  tgard_convert u_convert (
    .pix (s1_r),
    .res (conv)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r           <= FMT_24;
      rle_on_r        <= 1'b0;
      alpha_on_r      <= 1'b0;
      mapped_r        <= 1'b0;
      packet_left_r   <= 8'd0;
      packet_repeat_r <= 1'b0;
      byte_slot_r     <= 2'd0;
      pixel_bytes_r   <= 32'd0;
      pixels_left_r   <= 32'd1;
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_ch.index)
          CFG_PIXEL_FORMAT: fmt_r      <= cfg_ch.data[1:0];
          CFG_RLE_ON:       rle_on_r   <= cfg_ch.data[0];
          CFG_ALPHA_ON:     alpha_on_r <= cfg_ch.data[0];
          CFG_MAPPED:       mapped_r   <= cfg_ch.data[0];
          CFG_PIXEL_TOTAL: begin
            packet_left_r   <= 8'd0;
            packet_repeat_r <= 1'b0;
            byte_slot_r     <= 2'd0;
            pixel_bytes_r   <= 32'd0;
            pixels_left_r   <= cfg_ch.data;
          end
          default: begin
          end
        endcase
      end else begin
        packet_left_r   <= packet_left_nxt;
        packet_repeat_r <= packet_repeat_nxt;
        byte_slot_r     <= byte_slot_nxt;
        pixel_bytes_r   <= pixel_bytes_nxt;
        pixels_left_r   <= pixels_left_nxt;
      end
      if (advance) begin
        s1_valid_r  <= s1_valid_nxt;
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_r  <= s1_nxt;
      out_r <= conv;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.index_value = out_r.index_value;
  assign out_ch.red         = out_r.red;
  assign out_ch.green       = out_r.green;
  assign out_ch.blue        = out_r.blue;
  assign out_ch.run_length  = out_r.run_length;
  assign out_ch.last_pixel  = out_r.last_pixel;

endmodule

@@ rtl/tgard_check.sv @@
module tgard_check (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_index_value,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic [7:0]  out_run_length,
  input logic        out_last_pixel
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output item dropped while stalled");

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_run_length != 8'd0)
    else $error("zero run length");

  a_index_or_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_index_value != 16'd0 |->
      out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0)
    else $error("index and color both set");

  a_nothing_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_pixel |=> !out_valid)
    else $error("item after end of image");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind tga_rle_pixel_decoder_top tgard_check u_tgard_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_index_value (out_ch.index_value),
  .out_red         (out_ch.red),
  .out_green       (out_ch.green),
  .out_blue        (out_ch.blue),
  .out_run_length  (out_ch.run_length),
  .out_last_pixel  (out_ch.last_pixel)
);
